[design/pfbu_pkg.sv]
// Shared types and constants of the per-channel PReLU forward/backward unit.
package pfbu_pkg;

    localparam int FUNC_W   = 3;
    localparam int DATA_W   = 16;
    localparam int INDEX_W  = 6;
    localparam int RESULT_W = 32;
    localparam int GRAD_W   = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SLOPE_CH_W = 7;

    // Q2.14 value 0.25, the reset value of every slope.
    localparam logic [DATA_W-1:0] SLOPE_RESET = 16'h1000;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_FORWARD     = 3'd0,
        FUNC_BACKWARD    = 3'd1,
        FUNC_UPDATE      = 3'd2,
        FUNC_WRITE_SLOPE = 3'd3,
        FUNC_READ_GRAD   = 3'd4,
        FUNC_READ_SLOPE  = 3'd5
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PLANE_SIZE      = 2'd0,
        REG_TENSOR_CHANNELS = 2'd1,
        REG_SLOPE_CHANNELS  = 2'd2,
        REG_LEARN_RATE      = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WB
    } t_state;

endpackage

[design/pfbu_channel_if.sv]
// Valid/ready channel interfaces for input words and result words.
interface pfbu_in_if
    import pfbu_pkg::*;
    ();
    logic                      valid;
    logic                      ready;
    logic [FUNC_W-1:0]         func;
    logic                      first;
    logic signed [DATA_W-1:0]  activation;
    logic signed [DATA_W-1:0]  upstream_grad;
    logic [INDEX_W-1:0]        entry_index;
    logic signed [DATA_W-1:0]  entry_value;

    modport source (output valid, func, first, activation, upstream_grad, entry_index,
                    entry_value, input ready);
    modport sink (input valid, func, first, activation, upstream_grad, entry_index,
                  entry_value, output ready);
endinterface

interface pfbu_out_if
    import pfbu_pkg::*;
    ();
    logic                        valid;
    logic                        ready;
    logic signed [RESULT_W-1:0]  result_value;

    modport source (output valid, result_value, input ready);
    modport sink (input valid, result_value, output ready);
endinterface

[design/pfbu_table.sv]
// Synchronous table memory with per-entry valid bits that stand in for the reset value.
module pfbu_table #(
    parameter int             DEPTH   = 64,
    parameter int             W       = 16,
    parameter logic [W-1:0]   RST_VAL = '0,
    parameter int             AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clr,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [W-1:0]  i_wr_data,
    output logic [W-1:0]  o_rd_data
);

    logic [W-1:0]     mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [W-1:0]     r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // An entry never written since reset or since the last clear reads as the reset value.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_clr || !r_valid[i_rd_addr]) begin
                r_rd_data <= RST_VAL;
            end else begin
                r_rd_data <= mem[i_rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/pfbu_chan_ctr.sv]
// Plane position and channel counters that place each streamed element in its channel.
module pfbu_chan_ctr
    import pfbu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic                  i_first,
    input  logic [DATA_W-1:0]     i_plane_size,
    input  logic [DATA_W-1:0]     i_tensor_channels,
    output logic [DATA_W-1:0]     o_channel
);

    logic [DATA_W-1:0] r_plane_pos, n_plane_pos;
    logic [DATA_W-1:0] r_chan, n_chan;
    logic [DATA_W-1:0] pos_base, chan_base, pos_inc, chan_inc, ps, tc;

    always_comb begin
        ps        = (i_plane_size == '0) ? DATA_W'(1) : i_plane_size;
        tc        = (i_tensor_channels == '0) ? DATA_W'(1) : i_tensor_channels;
        pos_base  = i_first ? '0 : r_plane_pos;
        chan_base = i_first ? '0 : r_chan;
        pos_inc   = pos_base + DATA_W'(1);
        chan_inc  = chan_base + DATA_W'(1);
        if (pos_inc >= ps) begin
            n_plane_pos = '0;
            n_chan      = (chan_inc >= tc) ? '0 : chan_inc;
        end else begin
            n_plane_pos = pos_inc;
            n_chan      = chan_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_pos <= '0;
            r_chan      <= '0;
        end else if (i_step) begin
            r_plane_pos <= n_plane_pos;
            r_chan      <= n_chan;
        end
    end

    assign o_channel = chan_base;

endmodule

[design/prelu_forward_backward_unit.sv]
// Top level of the per-channel PReLU unit: configuration, sequencer and fixed-point datapath.
// A result word is registered in the write-back stage of its input word.
// A word is taken only when idle; a slope update reads and writes back each slope in use.
// The sequence per word is a table read, a multiply stage and a write-back stage.
// Reset (synchronous, active low) sets all slopes to 0.25, all gradients to zero,
// the counters to zero and the registers to their defaults at the next rising clock edge.
module prelu_forward_backward_unit
    import pfbu_pkg::*;
#(
    parameter int MAX_CHANNELS = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    pfbu_in_if.sink                i_in,
    pfbu_out_if.source             o_out
);

    localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    // Saturate a wide signed value to the 16-bit signed range.
    function automatic logic signed [DATA_W-1:0] sat16(input logic signed [32:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 33'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -33'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // Saturate a 33-bit signed sum to the 32-bit signed range.
    function automatic logic signed [GRAD_W-1:0] sat32(input logic signed [32:0] v);
        logic signed [GRAD_W-1:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            r = v[GRAD_W-1:0];
        end
        return r;
    endfunction

    // Configuration registers.
    logic [DATA_W-1:0]     r_plane_size;
    logic [DATA_W-1:0]     r_tensor_channels;
    logic [SLOPE_CH_W-1:0] r_slope_channels;
    logic [DATA_W-1:0]     r_learn_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_size      <= DATA_W'(1);
            r_tensor_channels <= DATA_W'(1);
            r_slope_channels  <= SLOPE_CH_W'(1);
            r_learn_rate      <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_PLANE_SIZE:      r_plane_size      <= i_cfg_data;
                REG_TENSOR_CHANNELS: r_tensor_channels <= i_cfg_data;
                REG_SLOPE_CHANNELS:  r_slope_channels  <= i_cfg_data[SLOPE_CH_W-1:0];
                REG_LEARN_RATE:      r_learn_rate      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Number of slopes in use: zero acts as one, and it never exceeds the table depth.
    logic [DATA_W-1:0] n_slopes;
    always_comb begin
        n_slopes = DATA_W'(r_slope_channels);
        if (n_slopes == '0) begin
            n_slopes = DATA_W'(1);
        end else if (n_slopes > DATA_W'(MAX_CHANNELS)) begin
            n_slopes = DATA_W'(MAX_CHANNELS);
        end
    end

    // Sequencer and latched input word.
    t_state                    r_state, n_state;
    t_func                     r_func;
    logic signed [DATA_W-1:0]  r_x, r_go, r_ev;
    logic                      r_idx_ok;
    logic [AW-1:0]             r_addr, n_addr;

    logic in_fire, in_stream, rd_issue, more, needs_out, wb_go, out_load;
    logic [DATA_W-1:0] channel, chan_clamped;
    logic [AW:0]       next_i;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign in_stream  = in_fire && ((t_func'(i_in.func) == FUNC_FORWARD) ||
                                    (t_func'(i_in.func) == FUNC_BACKWARD));

    pfbu_chan_ctr u_chan_ctr (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step            (in_stream),
        .i_first           (i_in.first),
        .i_plane_size      (r_plane_size),
        .i_tensor_channels (r_tensor_channels),
        .o_channel         (channel)
    );

    // A channel beyond the slopes in use falls back to the last slope.
    assign chan_clamped = (channel >= n_slopes) ? (n_slopes - DATA_W'(1)) : channel;

    // Table datapath signals.
    logic [DATA_W-1:0]         slope_rd_raw;
    logic [GRAD_W-1:0]         grad_rd_raw;
    logic signed [DATA_W-1:0]  slope_rd;
    logic signed [GRAD_W-1:0]  grad_rd;
    logic                      slope_we, grad_we, grad_clr;
    logic signed [DATA_W-1:0]  slope_wdata;
    logic signed [GRAD_W-1:0]  grad_wdata;

    assign slope_rd = $signed(slope_rd_raw);
    assign grad_rd  = $signed(grad_rd_raw);
    assign grad_clr = in_fire && (t_func'(i_in.func) == FUNC_BACKWARD) && i_in.first;

    // Write-back stage arithmetic.
    logic signed [RESULT_W-1:0] r_p1, r_p2;
    logic signed [48:0]         r_pu;
    logic signed [DATA_W-1:0]   r_slope;
    logic signed [GRAD_W-1:0]   r_grad;
    logic signed [32:0]         rnd1, grad_sum, slope_diff;
    logic signed [18:0]         q1;
    logic signed [49:0]         rndu;
    logic signed [31:0]         delta;
    logic signed [DATA_W-1:0]   prod_sat, slope_new;
    logic signed [RESULT_W-1:0] result;

    always_comb begin
        // Round half up on the Q10.22 product back to Q8.8.
        rnd1       = 33'(r_p1) + 33'sd8192;
        q1         = 19'(rnd1 >>> 14);
        prod_sat   = sat16(33'(q1));
        grad_sum   = 33'(r_grad) + 33'(r_p2);
        // learn_rate * grad is Q16.32; round half up to Q2.14.
        rndu       = 50'(r_pu) + 50'sd131072;
        delta      = 32'(rndu >>> 18);
        slope_diff = 33'(r_slope) - 33'(delta);
        slope_new  = sat16(slope_diff);

        unique case (r_func)
            FUNC_FORWARD:    result = (r_x > 16'sd0) ? 32'(r_x) : 32'(prod_sat);
            FUNC_BACKWARD:   result = (r_x > 16'sd0) ? 32'(r_go) : 32'(prod_sat);
            FUNC_READ_GRAD:  result = r_idx_ok ? r_grad : '0;
            FUNC_READ_SLOPE: result = r_idx_ok ? 32'(r_slope) : '0;
            default:         result = '0;
        endcase
    end

    assign next_i    = {1'b0, r_addr} + (AW+1)'(1);
    assign more      = (r_func == FUNC_UPDATE) && (DATA_W'(next_i) < n_slopes);
    assign needs_out = !more;

    // Output register.
    logic                       r_out_valid;
    logic signed [RESULT_W-1:0] r_out_value;

    assign wb_go    = (r_state == S_WB) && !(needs_out && r_out_valid && !o_out.ready);
    assign out_load = wb_go && needs_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_value <= result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.result_value = r_out_value;

    // Next state, read issue and write-back control.
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        rd_issue    = 1'b0;
        slope_we    = 1'b0;
        grad_we     = 1'b0;
        slope_wdata = r_ev;
        grad_wdata  = sat32(grad_sum);
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    rd_issue = 1'b1;
                    n_state  = S_READ;
                    unique case (t_func'(i_in.func))
                        FUNC_FORWARD, FUNC_BACKWARD: n_addr = AW'(chan_clamped);
                        FUNC_UPDATE:                 n_addr = '0;
                        default:                     n_addr = AW'(i_in.entry_index);
                    endcase
                end
            end
            S_READ: begin
                n_state = S_WB;
            end
            S_WB: begin
                if (wb_go) begin
                    unique case (r_func)
                        FUNC_BACKWARD: begin
                            grad_we = (r_x < 16'sd0);
                        end
                        FUNC_UPDATE: begin
                            slope_we    = 1'b1;
                            slope_wdata = slope_new;
                        end
                        FUNC_WRITE_SLOPE: begin
                            slope_we = r_idx_ok;
                        end
                        default: ;
                    endcase
                    if (more) begin
                        // Walk on to the next slope of the update.
                        rd_issue = 1'b1;
                        n_addr   = next_i[AW-1:0];
                        n_state  = S_READ;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        if (in_fire) begin
            r_func   <= t_func'(i_in.func);
            r_x      <= i_in.activation;
            r_go     <= i_in.upstream_grad;
            r_ev     <= i_in.entry_value;
            r_idx_ok <= (DATA_W'(i_in.entry_index) < DATA_W'(MAX_CHANNELS));
        end
    end

    // Multiply stage: table data arrives in the cycle after the read was issued.
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_slope <= slope_rd;
            r_grad  <= grad_rd;
            r_p1    <= 32'(slope_rd) * ((r_func == FUNC_FORWARD) ? 32'(r_x) : 32'(r_go));
            r_p2    <= 32'(r_go) * 32'(r_x);
            r_pu    <= 49'($signed({1'b0, r_learn_rate})) * 49'(grad_rd);
        end
    end

    pfbu_table #(
        .DEPTH   (MAX_CHANNELS),
        .W       (DATA_W),
        .RST_VAL (SLOPE_RESET),
        .AW      (AW)
    ) u_slope_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (1'b0),
        .i_rd_en   (rd_issue),
        .i_rd_addr (n_addr),
        .i_wr_en   (slope_we),
        .i_wr_addr (r_addr),
        .i_wr_data (slope_wdata),
        .o_rd_data (slope_rd_raw)
    );

    pfbu_table #(
        .DEPTH   (MAX_CHANNELS),
        .W       (GRAD_W),
        .RST_VAL ('0),
        .AW      (AW)
    ) u_grad_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (grad_clr),
        .i_rd_en   (rd_issue),
        .i_rd_addr (n_addr),
        .i_wr_en   (grad_we),
        .i_wr_addr (r_addr),
        .i_wr_data (grad_wdata),
        .o_rd_data (grad_rd_raw)
    );

endmodule
